>>> hw/rtl/m3mf_pkg.sv
// Package for the median-of-three block-average filter.
// Holds the widths, register indexes, state encodings and the job record.
// Used by every module of the filter; depends on nothing.
package m3mf_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = 8;
  localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int CHAN_BITS     = 5;
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int STEP_BITS     = $clog2(SUM_BITS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_AVERAGE_COUNT  = 1'b0,
    CFG_CHANNEL_SELECT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_WAIT = 2'd2
  } bk_state_e;

  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic [CHAN_BITS-1:0]  channel;
  } job_t;

endpackage

>>> hw/rtl/m3mf_front.sv
// Front end of the filter: configuration registers, sample triples, median
// and block accumulation. Emits one division job per completed block.
// Depends on m3mf_pkg.
module m3mf_front import m3mf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     accept_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     job_push_o,
  output job_t                     job_o
);

  function automatic logic [SAMPLE_BITS-1:0] middle_of(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b,
    input logic [SAMPLE_BITS-1:0] c
  );
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (c > hi) begin
      return hi;
    end else if (c > lo) begin
      return c;
    end
    return lo;
  endfunction

  logic [COUNT_BITS-1:0]  avg_count_q;
  logic [CHAN_BITS-1:0]   chan_q;
  phase_e                 phase_q, phase_d;
  logic [COUNT_BITS-1:0]  tally_q, tally_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] first_q, second_q;

  logic [SAMPLE_BITS-1:0] med;
  logic [SUM_BITS-1:0]    sum_add;
  logic [COUNT_BITS-1:0]  tally_add;
  logic [COUNT_BITS-1:0]  count_eff;
  logic                   block_done;

  assign med        = middle_of(first_q, second_q, sample_i);
  assign sum_add    = sum_q + {{COUNT_BITS{1'b0}}, med};
  assign tally_add  = tally_q + COUNT_BITS'(1);
  assign count_eff  = (avg_count_q == '0) ? COUNT_BITS'(1) : avg_count_q;
  assign block_done = (tally_add >= count_eff);

  always_comb begin
    phase_d    = phase_q;
    tally_d    = tally_q;
    sum_d      = sum_q;
    job_push_o = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_SECOND: begin
          phase_d = PH_THIRD;
        end
        PH_THIRD: begin
          phase_d = PH_FIRST;
          if (block_done) begin
            job_push_o = 1'b1;
            tally_d    = '0;
            sum_d      = '0;
          end else begin
            tally_d = tally_add;
            sum_d   = sum_add;
          end
        end
        default: begin
          phase_d = PH_SECOND;
        end
      endcase
    end
  end

  assign job_o.sum     = sum_add;
  assign job_o.count   = count_eff;
  assign job_o.channel = chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_count_q <= COUNT_BITS'(1);
      chan_q      <= '0;
      phase_q     <= PH_FIRST;
      tally_q     <= '0;
      sum_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_AVERAGE_COUNT:  avg_count_q <= cfg_data_i[COUNT_BITS-1:0];
          CFG_CHANNEL_SELECT: chan_q      <= cfg_data_i[CHAN_BITS-1:0];
          default: ;
        endcase
      end
      phase_q <= phase_d;
      tally_q <= tally_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
    end else if (accept_i) begin
      if (phase_q == PH_SECOND) begin
        second_q <= sample_i;
      end else if (phase_q != PH_THIRD) begin
        first_q <= sample_i;
      end
    end
  end

endmodule

>>> hw/rtl/m3mf_queue.sv
// Short job queue between the front end and the divider.
// Two entries of job_t with read and write pointers and a fill count.
// Depends on m3mf_pkg.
module m3mf_queue import m3mf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t                 entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] fill_q;
  logic                 do_push, do_pop;

  assign full_o  = (fill_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hw/rtl/m3mf_back.sv
// Back end of the filter: restoring divider, one quotient bit per cycle,
// saturation to the sample range and the output register.
// Depends on m3mf_pkg.
module m3mf_back import m3mf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  job_t                   job_i,
  output logic                   job_pop_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [SAMPLE_BITS-1:0] average_o,
  output logic [CHAN_BITS-1:0]   source_channel_o
);

  bk_state_e              state_q, state_d;
  logic [STEP_BITS-1:0]   step_q;
  logic [COUNT_BITS-1:0]  rem_q;
  logic [SUM_BITS-1:0]    quo_q;
  logic [COUNT_BITS-1:0]  div_q;
  logic [CHAN_BITS-1:0]   chan_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;
  logic [CHAN_BITS-1:0]   out_chan_q;

  logic [COUNT_BITS:0]    trial;
  logic                   trial_ge;
  logic [COUNT_BITS:0]    trial_sub;
  logic                   load_out;
  logic                   last_step;
  logic [SAMPLE_BITS-1:0] quo_sat;

  assign trial     = {rem_q, quo_q[SUM_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, div_q});
  assign trial_sub = trial - {1'b0, div_q};
  assign last_step = (step_q == STEP_BITS'(SUM_BITS - 1));
  assign quo_sat   = (quo_q > SUM_BITS'({SAMPLE_BITS{1'b1}})) ? {SAMPLE_BITS{1'b1}}
                                                             : quo_q[SAMPLE_BITS-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (job_valid_i) state_d = BK_DIV;
      BK_DIV:  if (last_step) state_d = BK_WAIT;
      BK_WAIT: if (!out_valid_q || pop_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      BK_IDLE: job_pop_o = job_valid_i;
      BK_WAIT: load_out  = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        step_q <= '0;
      end else if (state_q == BK_DIV) begin
        step_q <= step_q + STEP_BITS'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      rem_q  <= '0;
      quo_q  <= job_i.sum;
      div_q  <= job_i.count;
      chan_q <= job_i.channel;
    end else if (state_q == BK_DIV) begin
      rem_q <= trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_q <= {quo_q[SUM_BITS-2:0], trial_ge};
    end
    if (load_out) begin
      out_avg_q  <= quo_sat;
      out_chan_q <= chan_q;
    end
  end

  assign empty_o          = !out_valid_q;
  assign average_o        = out_avg_q;
  assign source_channel_o = out_chan_q;

endmodule

>>> hw/rtl/median3_mean_filter.sv
// Median-of-three block-average filter, top level.
// Takes one sample per cycle while the queue is not full; the divider takes one
// job at a time, one quotient bit a cycle, then waits for the output register.
// A two-entry job queue lets the front keep taking samples during a division;
// the input stalls only while the queue holds two jobs.
// Reset clears the phase, tally, sum, queue and output valid flag; average_count
// resets to 1 and channel_select to 0.
module median3_mean_filter import m3mf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     push,
  output logic                     full,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [SAMPLE_BITS-1:0]   average_o,
  output logic [CHAN_BITS-1:0]     source_channel_o
);

  logic accept;
  logic q_push, q_pop, q_full, q_empty;
  job_t front_job, q_job;

  assign accept = push && !q_full;
  assign full   = q_full;

  m3mf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .job_push_o (q_push),
    .job_o      (front_job)
  );

  m3mf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .pop_i   (q_pop),
    .job_o   (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  m3mf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (!q_empty),
    .job_i            (q_job),
    .job_pop_o        (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .average_o        (average_o),
    .source_channel_o (source_channel_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("job taken from an empty queue");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_job.count != '0))
    else $error("division job with a zero count");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for median3_mean_filter: a stimulus table, then random
// phases, checked against the table or an in-bench model. Depends on m3mf_pkg.
module testbench;
  import m3mf_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_PHASE = 2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] avg;
    logic [CHAN_BITS-1:0]   chan;
  } filter_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE} rx_mode_e;

  typedef struct {
    row_kind_e              kind;
    cfg_reg_e               idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [SAMPLE_BITS-1:0] smp;
    bit                     typed;
    filter_result_t         want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = CFG_AVERAGE_COUNT;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [SAMPLE_BITS-1:0] sample_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SAMPLE_BITS-1:0] average_o;
  logic [CHAN_BITS-1:0] source_channel_o;

  median3_mean_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .sample_i         (sample_i),
    .empty            (empty),
    .pop              (pop),
    .average_o        (average_o),
    .source_channel_o (source_channel_o)
  );

  always #5 clk_i = ~clk_i;

  // Model state of the filter and its registers.
  logic [SAMPLE_BITS-1:0] held_a, held_b;
  phase_e                 slot;
  logic [COUNT_BITS-1:0]  median_count;
  logic [SUM_BITS-1:0]    median_sum;
  logic [COUNT_BITS-1:0]  block_len;
  logic [CHAN_BITS-1:0]   chan_sel;

  filter_result_t pending_results[$];
  stim_row_t      directed_rows[$];
  int  items_sent = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  long_hold_req = 1'b0;

  function automatic bit filter_sample(input logic [SAMPLE_BITS-1:0] s,
                                       output filter_result_t res);
    logic [SAMPLE_BITS-1:0] lo, hi, mid;
    logic [COUNT_BITS-1:0]  divisor;
    logic [SUM_BITS-1:0]    quotient;
    res = '0;
    if (slot == PH_SECOND) begin
      held_b = s;
      slot = PH_THIRD;
      return 1'b0;
    end
    if (slot != PH_THIRD) begin
      held_a = s;
      slot = PH_SECOND;
      return 1'b0;
    end
    slot = PH_FIRST;
    lo = held_a;
    hi = held_b;
    if (lo > hi) begin
      lo = held_b;
      hi = held_a;
    end
    mid = (s > hi) ? hi : ((s > lo) ? s : lo);
    median_sum = median_sum + SUM_BITS'(mid);
    median_count = median_count + COUNT_BITS'(1);
    divisor = (block_len == '0) ? COUNT_BITS'(1) : block_len;
    if (median_count < divisor) return 1'b0;
    quotient = median_sum / SUM_BITS'(divisor);
    res.avg = (quotient > SUM_BITS'({SAMPLE_BITS{1'b1}})) ? '1 : quotient[SAMPLE_BITS-1:0];
    res.chan = chan_sel;
    median_sum = '0;
    median_count = '0;
    return 1'b1;
  endfunction

  task automatic offer(input logic [SAMPLE_BITS-1:0] s, input bit typed,
                       input filter_result_t typed_want);
    filter_result_t res;
    bit got;
    @(negedge clk_i);
    push <= 1'b1;
    sample_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    got = filter_sample(s, res);
    if (typed) pending_results.push_back(typed_want);
    else if (got) pending_results.push_back(res);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_AVERAGE_COUNT) block_len = data;
    else chan_sel = data[CHAN_BITS-1:0];
  endtask

  function automatic stim_row_t make_row(row_kind_e kind, cfg_reg_e idx,
                                         logic [CFG_DATA_BITS-1:0] data,
                                         logic [SAMPLE_BITS-1:0] smp, bit typed,
                                         logic [SAMPLE_BITS-1:0] avg,
                                         logic [CHAN_BITS-1:0] chan);
    stim_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.data = data;
    r.smp = smp;
    r.typed = typed;
    r.want.avg = avg;
    r.want.chan = chan;
    return r;
  endfunction

  function automatic stim_row_t smp_row(logic [SAMPLE_BITS-1:0] smp);
    return make_row(ROW_SAMPLE, CFG_AVERAGE_COUNT, '0, smp, 1'b0, '0, '0);
  endfunction

  function automatic stim_row_t last_row(logic [SAMPLE_BITS-1:0] smp,
                                         logic [SAMPLE_BITS-1:0] avg,
                                         logic [CHAN_BITS-1:0] chan);
    return make_row(ROW_SAMPLE, CFG_AVERAGE_COUNT, '0, smp, 1'b1, avg, chan);
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
    return make_row(ROW_WRITE, idx, data, '0, 1'b0, '0, '0);
  endfunction

  // Receiver: changes its stall pattern now and then, and holds off for a long
  // stretch when the sender asks for it.
  initial begin : receiver
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    mode = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY: pop <= 1'b1;
          RX_HALF:   pop <= 1'($urandom_range(0, 1));
          default:   pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result average=%0d channel=%0d", $time,
                 average_o, source_channel_o);
      end else begin
        want = pending_results.pop_front();
        if (average_o !== want.avg) begin
          mismatches++;
          $display("%0t: average expected %0d, got %0d", $time, want.avg, average_o);
        end
        if (source_channel_o !== want.chan) begin
          mismatches++;
          $display("%0t: source_channel expected %0d, got %0d", $time, want.chan,
                   source_channel_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int phase_no;
    int n_items;
    int burst_left;
    logic [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0] prev;
    logic [COUNT_BITS-1:0] count;
    stim_row_t row;

    held_a = '0;
    held_b = '0;
    slot = PH_FIRST;
    median_count = '0;
    median_sum = '0;
    block_len = COUNT_BITS'(1);
    chan_sel = '0;

    directed_rows.push_back(smp_row(12'd0));
    directed_rows.push_back(smp_row(12'd0));
    directed_rows.push_back(last_row(12'd0, 12'd0, 5'd0));
    directed_rows.push_back(smp_row(12'd4095));
    directed_rows.push_back(smp_row(12'd4095));
    directed_rows.push_back(last_row(12'd4095, 12'd4095, 5'd0));
    directed_rows.push_back(smp_row(12'd1));
    directed_rows.push_back(smp_row(12'd3));
    directed_rows.push_back(smp_row(12'd2));
    directed_rows.push_back(smp_row(12'd5));
    directed_rows.push_back(smp_row(12'd9));
    directed_rows.push_back(last_row(12'd5, 12'd5, 5'd0));
    // A count of zero behaves as one; upper data bits of the channel are dropped.
    directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 8'd0));
    directed_rows.push_back(cfg_row(CFG_CHANNEL_SELECT, 8'hFF));
    directed_rows.push_back(smp_row(12'd7));
    directed_rows.push_back(smp_row(12'd100));
    directed_rows.push_back(last_row(12'd50, 12'd50, 5'd31));
    // Lowering the count mid-block gives a result at once, saturated.
    directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 8'd255));
    repeat (6) directed_rows.push_back(smp_row(12'd4095));
    directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 8'd1));
    directed_rows.push_back(smp_row(12'd4095));
    directed_rows.push_back(smp_row(12'd4095));
    directed_rows.push_back(last_row(12'd4095, 12'd4095, 5'd31));
    directed_rows.push_back(smp_row(12'hAAA));
    directed_rows.push_back(smp_row(12'h555));
    directed_rows.push_back(smp_row(12'h800));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_register(row.idx, row.data);
      end else begin
        offer(row.smp, row.typed, row.want);
      end
    end

    phase_no = 0;
    prev = '0;
    while (items_sent < 800) begin
      drain_results();
      case ($urandom_range(0, 9))
        0:       count = '0;
        1:       count = COUNT_BITS'(1);
        2, 3, 4: count = COUNT_BITS'($urandom_range(2, 6));
        5, 6, 7: count = COUNT_BITS'($urandom_range(7, 20));
        default: count = COUNT_BITS'($urandom_range(21, 255));
      endcase
      if (phase_no == PRESSURE_PHASE) count = COUNT_BITS'(1);
      write_register(CFG_AVERAGE_COUNT, count);
      write_register(CFG_CHANNEL_SELECT, CFG_DATA_BITS'($urandom_range(0, 255)));
      n_items = (phase_no == PRESSURE_PHASE) ? 90 : $urandom_range(30, 90);
      if (phase_no == PRESSURE_PHASE) long_hold_req = 1'b1;
      burst_left = $urandom_range(1, 24);
      for (i = 0; i < n_items; i++) begin
        case ($urandom_range(0, 9))
          0:       s = '0;
          1:       s = '1;
          2:       s = prev;
          3:       s = SAMPLE_BITS'($urandom_range(0, 15));
          default: s = SAMPLE_BITS'($urandom_range(0, 4095));
        endcase
        prev = s;
        offer(s, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (phase_no != PRESSURE_PHASE && $urandom_range(0, 3) != 0)
            idle_cycles($urandom_range(1, 6));
        end
      end
      phase_no++;
    end

    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/m3mf_pkg.sv
hw/rtl/m3mf_front.sv
hw/rtl/m3mf_queue.sv
hw/rtl/m3mf_back.sv
hw/rtl/median3_mean_filter.sv
tb/sv/testbench.sv
